// ===== sv/pxd_pkg.sv =====
package pxd_pkg;

    // Key multiplier applied to the packet size
    localparam logic [31:0] KeyMul = 32'h6765_7268;

    // Smallest index the embedded index byte may hold
    localparam logic [7:0] IndexMin = 8'd10;

    // Table offsets at or above this limit skip the table-byte check
    localparam logic [7:0] TextLimit = 8'd220;

    // Inversion mask used by the index-byte and table-byte checks
    localparam logic [7:0] InvMask = 8'hFF;

    // Position counter saturation value
    localparam logic [15:0] PosMax = 16'hFFFF;

    // Result status codes, valid on the last byte of a packet
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_INDEX_RANGE = 2'd1,
        STATUS_INDEX_BYTE  = 2'd2,
        STATUS_TABLE_BYTE  = 2'd3
    } status_t;

    // Text table, 256 bytes; character 0 sits in the top byte
    localparam logic [256*8-1:0] TextRom = {
        "As part of this software beta version \115irabilis is ",
        "granting a limited access to the \111CQ network, ",
        "servers, directories, listings, information and databases (\"",
        "\111CQ Services and Information\"). The ",
        "\111CQ Service and Information may databases (\"",
        "\111CQ Services and In"
    };

    // Look up one table byte; byte i lives at bit offset (255 - i) * 8
    function automatic logic [7:0] text_byte(input logic [7:0] idx);
        logic [10:0] bit_ofs;
        bit_ofs = {~idx, 3'b000};
        return TextRom[bit_ofs +: 8];
    endfunction

endpackage

// ===== sv/pxd_if.sv =====
// Input channel: one scrambled packet byte per item
interface pxd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] packet_size;

    modport source (output valid, output data_byte, output first, output packet_size,
                    input ready);
    modport sink (input valid, input data_byte, input first, input packet_size,
                  output ready);
endinterface

// Output channel: one descrambled byte per item
interface pxd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  plain_byte;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, output plain_byte, output last, output status,
                    input ready);
    modport sink (input valid, input plain_byte, input last, input status,
                  output ready);
endinterface

// ===== sv/peer_packet_xor_descrambler.sv =====
// Peer packet XOR descrambler. Feed the packet one byte per item on din, starting
// at the 4-byte little-endian check word, with first set on that byte and
// packet_size (bytes from check word to end) presented with it. Each item yields
// exactly one item on dout in the next cycle: the check word passes unchanged, and
// the 4-byte groups with base index b in 4 <= b < (size+3)/4 are XORed with
// key + table[b & 255], where key = 0x67657268 * size + check word. On the final
// byte (last = 1) status reports 0 ok, 1 index out of range, 2 index byte bad,
// 3 table byte bad; it reads 0 on other bytes. Unstalled, it takes one item per clock:
// the descramble path is one 32-bit add, a table read and the checks between the
// state registers and the output register, and the key multiply is registered
// when the first byte is taken. din stays ready while the output register is
// empty or being drained, so a stalled sink costs no bubble beyond the stall.
module peer_packet_xor_descrambler
    import pxd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pxd_in_if.sink        din,
    pxd_out_if.source     dout
);

    // Per-packet state
    logic [15:0] pos_reg, pos_next;
    logic [15:0] size_reg, size_next;
    logic [31:0] check_reg, check_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] size_mul_reg, size_mul_next;
    logic [7:0]  byte_four_reg, byte_four_next;
    logic [31:0] verify_reg, verify_next;
    logic        idx_ok_reg, idx_ok_next;
    logic        idx_byte_ok_reg, idx_byte_ok_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  plain_reg, plain_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;

    logic        accept;

    // Working values of the current item
    logic [15:0] cur_pos;
    logic [15:0] cur_size;
    logic [15:0] base;
    logic [16:0] group_limit;
    logic [31:0] pad;
    logic [31:0] b_word;
    logic [7:0]  idx_m;
    logic [7:0]  x2;
    logic        is_last;

    // Take a new item whenever the output register is empty or draining
    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    assign dout.valid      = out_valid_reg;
    assign dout.plain_byte = plain_reg;
    assign dout.last       = last_reg;
    assign dout.status     = status_reg;

    // Descramble one byte and update the packet state
    always_comb
    begin
        // Restart the packet state on a first byte
        cur_pos          = din.first ? 16'd0 : pos_reg;
        cur_size         = din.first ? din.packet_size : size_reg;
        check_next       = din.first ? 32'd0 : check_reg;
        key_next         = din.first ? 32'd0 : key_reg;
        byte_four_next   = din.first ? 8'd0 : byte_four_reg;
        verify_next      = din.first ? 32'd0 : verify_reg;
        idx_ok_next      = din.first ? 1'b0 : idx_ok_reg;
        idx_byte_ok_next = din.first ? 1'b0 : idx_byte_ok_reg;
        size_next        = cur_size;
        size_mul_next    = din.first ? KeyMul * {16'd0, din.packet_size} : size_mul_reg;

        plain_next  = din.data_byte;
        base        = {cur_pos[15:2], 2'b00};
        group_limit = ({1'b0, cur_size} + 17'd3) >> 2;
        pad         = key_next + {24'd0, text_byte(base[7:0])};
        b_word      = 32'd0;
        idx_m       = 8'd0;

        // Collect the check word, then XOR the groups in range
        if (cur_pos < 16'd4)
        begin
            check_next = check_next | ({24'd0, din.data_byte} << {cur_pos[1:0], 3'b000});
            if (cur_pos == 16'd3)
            begin
                key_next = size_mul_reg + check_next;
            end
        end
        else if ({1'b0, base} < group_limit)
        begin
            plain_next = din.data_byte ^ pad[{cur_pos[1:0], 3'b000} +: 8];
        end

        // Capture the checks' inputs
        if (cur_pos == 16'd4)
        begin
            byte_four_next = plain_next;
        end
        if (cur_pos == 16'd6)
        begin
            b_word      = {byte_four_next, plain_next, byte_four_next, plain_next};
            verify_next = b_word ^ check_next;
            idx_m       = verify_next[31:24];
            idx_ok_next = (idx_m >= IndexMin) && ({8'd0, idx_m} < cur_size);
        end
        if (cur_pos > 16'd6 && idx_ok_next && cur_pos == {8'd0, verify_next[31:24]})
        begin
            idx_byte_ok_next = (verify_next[23:16] == (plain_next ^ InvMask));
        end

        // Report the checks on the last byte
        is_last     = ({1'b0, cur_pos} + 17'd1) >= {1'b0, cur_size};
        x2          = verify_next[15:8];
        status_next = STATUS_OK;
        if (is_last)
        begin
            if (!idx_ok_next)
            begin
                status_next = STATUS_INDEX_RANGE;
            end
            else if (!idx_byte_ok_next)
            begin
                status_next = STATUS_INDEX_BYTE;
            end
            else if (x2 < TextLimit && verify_next[7:0] != (text_byte(x2) ^ InvMask))
            begin
                status_next = STATUS_TABLE_BYTE;
            end
        end
        last_next = is_last;

        // Advance the position, saturating
        pos_next = (cur_pos < PosMax) ? cur_pos + 16'd1 : cur_pos;

        out_valid_next = accept || (out_valid_reg && !dout.ready);
    end

    // Hold control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 16'd0;
            size_reg        <= 16'd0;
            check_reg       <= 32'd0;
            key_reg         <= 32'd0;
            size_mul_reg    <= 32'd0;
            byte_four_reg   <= 8'd0;
            verify_reg      <= 32'd0;
            idx_ok_reg      <= 1'b0;
            idx_byte_ok_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pos_reg         <= pos_next;
                size_reg        <= size_next;
                check_reg       <= check_next;
                key_reg         <= key_next;
                size_mul_reg    <= size_mul_next;
                byte_four_reg   <= byte_four_next;
                verify_reg      <= verify_next;
                idx_ok_reg      <= idx_ok_next;
                idx_byte_ok_reg <= idx_byte_ok_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plain_reg  <= plain_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

`ifndef ASSERT_OFF
    // Status stays zero except on the last byte
    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.last |-> dout.status == STATUS_OK)
        else $error("status set on a byte that is not last");

    // The first byte of a packet is part of the check word and passes unchanged
    a_first_passes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && din.first |=> dout.valid && dout.plain_byte == $past(din.data_byte))
        else $error("check word byte altered");

    // Check word bytes pass unchanged within a packet
    a_check_passes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !din.first && pos_reg < 16'd4 |=> dout.plain_byte == $past(din.data_byte))
        else $error("check word byte altered");

    // Position advances by one per item until it saturates
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !din.first && pos_reg != PosMax |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance");
`endif

endmodule

// ===== sim/tb_peer_packet_xor_descrambler.sv =====
`timescale 1ns / 100ps

module tb_peer_packet_xor_descrambler
    import pxd_pkg::*;
();

    localparam logic [31:0] KeyFactor   = 32'h6765_7268;
    localparam logic [7:0]  MinIndex    = 8'd10;
    localparam logic [7:0]  TableLimit  = 8'd220;
    localparam logic [7:0]  FlipMask    = 8'hFF;
    localparam logic [15:0] PosCeiling  = 16'hFFFF;
    localparam int          IdlePct     = 33;
    localparam int          RandomItems = 1250;
    localparam int          DrainCycles = 8;
    localparam int          CycleLimit  = 1_000_000;
    localparam int          MaxReports  = 10;
    localparam int          DirRows     = 23;
    localparam int          LargeSend   = 40;

    // Kinds of packet the random part builds
    typedef enum int {
        PKT_GOOD,
        PKT_RANGE,
        PKT_INDEX,
        PKT_TABLE,
        PKT_NOISE
    } pkt_kind_t;

    typedef struct packed {
        logic [7:0] plain;
        logic       last;
        status_t    status;
    } plain_res_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic [15:0] packet_size;
        logic        typed;
        logic [7:0]  plain;
        logic        last;
        status_t     status;
    } opening_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pxd_in_if  byte_in ();
    pxd_out_if byte_out ();

    peer_packet_xor_descrambler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (byte_in),
        .dout  (byte_out)
    );

    // Table text; only the first 256 characters are ever looked up
    string text_src = {
        "As part of this software beta version \115irabilis is ",
        "granting a limited access to the \111CQ network, ",
        "servers, directories, listings, information and databases (\"",
        "\111CQ Services and Information\"). The ",
        "\111CQ Service and Information may databases (\"",
        "\111CQ Services and Information\"). The "
    };

    // Opening rows: after reset, tiny sizes, bytes past the end, the largest
    // size and a packet that ends before the index byte is known
    opening_row_t opening_rows [DirRows] = '{
        '{8'h3C, 1'b0, 16'h1234, 1'b1, 8'h3C, 1'b1, STATUS_INDEX_RANGE},
        '{8'hC3, 1'b0, 16'hEDCB, 1'b1, 8'hC3, 1'b1, STATUS_INDEX_RANGE},
        '{8'hFF, 1'b1, 16'h0000, 1'b1, 8'hFF, 1'b1, STATUS_INDEX_RANGE},
        '{8'h00, 1'b1, 16'h0001, 1'b1, 8'h00, 1'b1, STATUS_INDEX_RANGE},
        '{8'h11, 1'b1, 16'h0004, 1'b1, 8'h11, 1'b0, STATUS_OK},
        '{8'h22, 1'b0, 16'hFFFF, 1'b1, 8'h22, 1'b0, STATUS_OK},
        '{8'h33, 1'b0, 16'h0000, 1'b1, 8'h33, 1'b0, STATUS_OK},
        '{8'h44, 1'b0, 16'h0004, 1'b1, 8'h44, 1'b1, STATUS_INDEX_RANGE},
        '{8'h55, 1'b0, 16'h8000, 1'b1, 8'h55, 1'b1, STATUS_INDEX_RANGE},
        '{8'hAA, 1'b0, 16'h7FFF, 1'b1, 8'hAA, 1'b1, STATUS_INDEX_RANGE},
        '{8'hFF, 1'b1, 16'hFFFF, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, 16'h5A5A, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, 16'hA5A5, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, 16'hFFFF, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, 16'h0000, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, 16'hFFFF, 1'b0, 8'h00, 1'b0, STATUS_OK},
        '{8'h5A, 1'b1, 16'h0005, 1'b1, 8'h5A, 1'b0, STATUS_OK},
        '{8'hA5, 1'b0, 16'h0000, 1'b1, 8'hA5, 1'b0, STATUS_OK},
        '{8'h0F, 1'b0, 16'hFFFF, 1'b1, 8'h0F, 1'b0, STATUS_OK},
        '{8'hF0, 1'b0, 16'h0000, 1'b1, 8'hF0, 1'b0, STATUS_OK},
        '{8'hC6, 1'b0, 16'h0001, 1'b1, 8'hC6, 1'b1, STATUS_INDEX_RANGE}
    };

    // Descrambler state as tracked by the testbench
    logic [15:0] track_pos       = '0;
    logic [15:0] track_size      = '0;
    logic [31:0] track_check     = '0;
    logic [31:0] track_key       = '0;
    logic [7:0]  track_byte4     = '0;
    logic [31:0] track_verify    = '0;
    logic        track_idx_ok    = 1'b0;
    logic        track_idx_match = 1'b0;

    plain_res_t plain_due_q [$];
    plain_res_t got_res;
    plain_res_t want_res;
    int         mismatch_cnt = 0;
    int         sent_items   = 0;
    int         cycle_cnt    = 0;
    bit         gaps_on      = 1'b1;

    function automatic logic [7:0] text_char(input logic [7:0] idx);
        return text_src[idx];
    endfunction

    // Key stream byte for one position, zero outside the scrambled groups
    function automatic logic [7:0] pad_byte(input logic [31:0] key, input int unsigned pos,
                                            input int unsigned pkt_size);
        int unsigned base;
        logic [31:0] pad;
        base = pos & 32'hFFFF_FFFC;
        pad = key + {24'h0, text_char(base[7:0])};
        if (pos < 4 || base >= (pkt_size + 3) / 4)
            return 8'h00;
        return pad[8 * (pos % 4) +: 8];
    endfunction

    // Descramble one byte and advance the tracked state
    function automatic plain_res_t descramble_byte(input logic [7:0] d, input logic f,
                                                   input logic [15:0] sz);
        plain_res_t  r;
        int unsigned pos;
        logic [7:0]  p;
        logic [7:0]  idx;
        logic [7:0]  ofs;
        if (f)
        begin
            track_pos       = '0;
            track_size      = sz;
            track_check     = '0;
            track_key       = '0;
            track_byte4     = '0;
            track_verify    = '0;
            track_idx_ok    = 1'b0;
            track_idx_match = 1'b0;
        end
        pos = track_pos;
        p = d;

        // collect the check word, then unscramble the key stream groups
        if (pos < 4)
        begin
            track_check[8 * pos +: 8] = d;
            if (pos == 3)
                track_key = KeyFactor * {16'h0, track_size} + track_check;
        end
        else
            p = d ^ pad_byte(track_key, pos, track_size);

        // build the verify word and run the index checks
        if (pos == 4)
            track_byte4 = p;
        if (pos == 6)
        begin
            track_verify = {track_byte4, p, track_byte4, p} ^ track_check;
            idx = track_verify[31:24];
            track_idx_ok = (idx >= MinIndex) && ({8'h0, idx} < track_size);
        end
        if (pos > 6 && track_idx_ok && pos == track_verify[31:24])
            track_idx_match = (track_verify[23:16] == (p ^ FlipMask));

        r.plain = p;
        r.last = (pos + 1 >= track_size);
        r.status = STATUS_OK;
        if (r.last)
        begin
            ofs = track_verify[15:8];
            if (!track_idx_ok)
                r.status = STATUS_INDEX_RANGE;
            else if (!track_idx_match)
                r.status = STATUS_INDEX_BYTE;
            else if (ofs < TableLimit && track_verify[7:0] != (text_char(ofs) ^ FlipMask))
                r.status = STATUS_TABLE_BYTE;
        end

        if (track_pos != PosCeiling)
            track_pos = track_pos + 16'd1;
        return r;
    endfunction

    // Offer one item on the input channel and hold it until it is taken
    task automatic drive_byte(input logic [7:0] d, input logic f, input logic [15:0] sz);
        while (gaps_on && $urandom_range(99) < IdlePct)
        begin
            byte_in.valid       <= 1'b0;
            byte_in.data_byte   <= 8'($urandom);
            byte_in.first       <= 1'($urandom);
            byte_in.packet_size <= 16'($urandom);
            @(negedge clk);
        end
        byte_in.valid       <= 1'b1;
        byte_in.data_byte   <= d;
        byte_in.first       <= f;
        byte_in.packet_size <= sz;
        @(posedge clk);
        while (!byte_in.ready)
            @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic f, input logic [15:0] sz);
        plain_due_q.push_back(descramble_byte(d, f, sz));
        drive_byte(d, f, sz);
    endtask

    // Build one packet of the given kind, scramble it and send it
    task automatic send_packet(input pkt_kind_t kind, input int unsigned fixed_size);
        int unsigned pkt_size;
        int unsigned extras;
        int unsigned n_send;
        int unsigned idx;
        logic [7:0]  body [];
        logic [7:0]  p4, p6, y, ofs, tail;
        logic [31:0] cw;
        logic [31:0] key;
        logic        lead_first;

        lead_first = 1'b1;
        if (kind == PKT_NOISE)
        begin
            case ($urandom_range(2))
                0: pkt_size = $urandom_range(0, 15);
                1: pkt_size = $urandom_range(16, 255);
                default: pkt_size = $urandom_range(0, 65535);
            endcase
            n_send = $urandom_range(1, 40);
            body = new[n_send];
            foreach (body[i])
                body[i] = 8'($urandom);
            lead_first = ($urandom_range(3) != 0);
        end
        else
        begin
            if (fixed_size != 0)
                pkt_size = fixed_size;
            else if ($urandom_range(9) == 0)
                pkt_size = $urandom_range(41, 300);
            else
                pkt_size = $urandom_range(11, 40);
            extras = (fixed_size != 0) ? 0 : (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);

            // pick the verify word fields for this kind
            idx = $urandom_range(10, (pkt_size > 256) ? 255 : pkt_size - 1);
            if (kind == PKT_RANGE)
                idx = (pkt_size <= 255 && $urandom_range(1)) ? $urandom_range(pkt_size, 255)
                                                              : $urandom_range(0, 9);
            p4 = 8'($urandom);
            p6 = 8'($urandom);
            y = 8'($urandom);
            ofs = (kind == PKT_TABLE) ? 8'($urandom_range(0, 219)) : 8'($urandom);
            tail = text_char(ofs) ^ FlipMask;
            if (kind == PKT_TABLE)
                tail = tail ^ 8'($urandom_range(1, 255));
            cw = {p4 ^ idx[7:0], p6 ^ y, p4 ^ ofs, p6 ^ tail};

            // plain content: check word, verify bytes, index byte, random rest
            body = new[pkt_size + extras];
            foreach (body[i])
                body[i] = 8'($urandom);
            body[0] = cw[7:0];
            body[1] = cw[15:8];
            body[2] = cw[23:16];
            body[3] = cw[31:24];
            body[4] = p4;
            body[6] = p6;
            if (idx > 6 && idx < pkt_size)
            begin
                body[idx] = y ^ FlipMask;
                if (kind == PKT_INDEX)
                    body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
            end
            key = KeyFactor * pkt_size + cw;

            // scramble the plain content the way the sender would
            foreach (body[i])
                body[i] = body[i] ^ pad_byte(key, i, pkt_size);
            n_send = pkt_size + extras;
            if (fixed_size != 0)
                n_send = LargeSend;
            else if ($urandom_range(9) == 0)
                n_send = $urandom_range(1, pkt_size - 1);
        end

        for (int i = 0; i < n_send; i++)
        begin
            if (i == 0)
                send_byte(body[i], lead_first, 16'(pkt_size));
            else
                send_byte(body[i], 1'b0, 16'($urandom));
        end
    endtask

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit)
        begin
            $display("FAIL peer_packet_xor_descrambler");
            $finish;
        end
    end

    // Stall the output channel at random
    always @(negedge clk)
        byte_out.ready <= !gaps_on || ($urandom_range(99) >= IdlePct);

    // Check every output item against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && byte_out.valid && byte_out.ready)
        begin
            got_res.plain  = byte_out.plain_byte;
            got_res.last   = byte_out.last;
            got_res.status = status_t'(byte_out.status);
            if (plain_due_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MaxReports)
                    $display("%0t: unexpected item: plain %02h last %b status %0d",
                             $realtime, got_res.plain, got_res.last, got_res.status);
            end
            else
            begin
                want_res = plain_due_q.pop_front();
                if (got_res.plain !== want_res.plain || got_res.last !== want_res.last ||
                    got_res.status !== want_res.status)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MaxReports)
                        $display("%0t: mismatch: plain %02h/%02h last %b/%b status %0d/%0d",
                                 $realtime, want_res.plain, got_res.plain, want_res.last,
                                 got_res.last, want_res.status, got_res.status);
                end
            end
        end
    end

    initial
    begin : stimulus
        plain_res_t res;
        int         pick;

        byte_in.valid       = 1'b0;
        byte_in.data_byte   = 8'h00;
        byte_in.first       = 1'b0;
        byte_in.packet_size = 16'h0000;
        byte_out.ready      = 1'b0;
        rst_n               = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // walk the opening rows; typed rows carry their own expectation
        for (int i = 0; i < DirRows; i++)
        begin
            res = descramble_byte(opening_rows[i].data_byte, opening_rows[i].first,
                                  opening_rows[i].packet_size);
            if (opening_rows[i].typed)
                res = '{opening_rows[i].plain, opening_rows[i].last, opening_rows[i].status};
            plain_due_q.push_back(res);
            drive_byte(opening_rows[i].data_byte, opening_rows[i].first,
                       opening_rows[i].packet_size);
        end

        // mostly well-formed packets, with a stretch free of gaps
        while (sent_items < DirRows + RandomItems)
        begin
            gaps_on = (sent_items < 500 || sent_items >= 800);
            pick = $urandom_range(99);
            if (pick < 40)
                send_packet(PKT_GOOD, 0);
            else if (pick < 50)
                send_packet(PKT_RANGE, 0);
            else if (pick < 60)
                send_packet(PKT_INDEX, 0);
            else if (pick < 70)
                send_packet(PKT_TABLE, 0);
            else
                send_packet(PKT_NOISE, 0);
        end

        // one packet of the largest size, cut short after its verify bytes
        gaps_on = 1'b1;
        send_packet(PKT_GOOD, 65535);

        byte_in.valid <= 1'b0;
        while (plain_due_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASS peer_packet_xor_descrambler");
        else
            $display("FAIL peer_packet_xor_descrambler");
        $finish;
    end

endmodule
